[design/lcf_pkg.sv]
// shared constants, types and pattern functions of the lbp code filter
package lcf_pkg;

	localparam int CFG_DW = 11;

	localparam logic [2:0] REG_IMAGE_WIDTH    = 3'd0;
	localparam logic [2:0] REG_IMAGE_HEIGHT   = 3'd1;
	localparam logic [2:0] REG_RADIUS         = 3'd2;
	localparam logic [2:0] REG_MAX_TRANS      = 3'd3;
	localparam logic [2:0] REG_ROT_INVARIANT  = 3'd4;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	typedef enum logic [1:0] {
		B_IDLE,
		B_READ,
		B_WRITE,
		B_NULL
	} build_state_t;

	function automatic logic [3:0] transitions(input logic [7:0] p);
		logic [3:0] n;
		n = 4'd0;
		for (int k = 0; k < 8; k++) begin
			n = n + 4'(p[k] != p[(k + 1) & 7]);
		end
		return n;
	endfunction

	function automatic logic [7:0] min_rotation(input logic [7:0] p);
		logic [7:0] best;
		logic [7:0] v;
		best = p;
		v = p;
		for (int k = 0; k < 8; k++) begin
			v = {v[0], v[7:1]};
			if (v < best) begin
				best = v;
			end
		end
		return best;
	endfunction

endpackage

[design/lcf_ram.sv]
// generic single write port, single registered read port ram
module lcf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[design/lcf_window.sv]
// banked line store and 3x3 neighbour compare producing the raw pattern
module lcf_window #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_RADIUS = 4
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [$clog2(2*MAX_RADIUS+1)-1:0]    wbank,
	input  logic [$clog2(MAX_WIDTH)-1:0]         wcol,
	input  logic [7:0]                           wdata,
	input  logic                                 re,
	input  logic [$clog2(2*MAX_RADIUS+1)-1:0]    bank_t,
	input  logic [$clog2(2*MAX_RADIUS+1)-1:0]    bank_m,
	input  logic [$clog2(2*MAX_RADIUS+1)-1:0]    bank_b,
	input  logic [$clog2(MAX_WIDTH)-1:0]         col_l,
	input  logic [$clog2(MAX_WIDTH)-1:0]         col_c,
	input  logic [$clog2(MAX_WIDTH)-1:0]         col_r,
	output logic [7:0]                           pattern
);

	localparam int NR = 2 * MAX_RADIUS + 1;
	localparam int BW = $clog2(NR);
	localparam int CA = $clog2(MAX_WIDTH);

	logic [CA-1:0] rcol [3];
	logic [7:0]    rd [NR][3];
	logic [BW-1:0] bank_t_s2, bank_m_s2, bank_b_s2;
	logic [7:0]    nw, n, ne, e, se, s, sw, w, c;

	assign rcol[0] = col_l;
	assign rcol[1] = col_c;
	assign rcol[2] = col_r;

	for (genvar b = 0; b < NR; b++) begin : g_bank
		for (genvar k = 0; k < 3; k++) begin : g_copy
			lcf_ram #(
				.WIDTH(8),
				.DEPTH(MAX_WIDTH)
			) u_ram (
				.clk  (clk),
				.we   (we && (wbank == BW'(b))),
				.waddr(wcol),
				.wdata(wdata),
				.re   (re),
				.raddr(rcol[k]),
				.rdata(rd[b][k])
			);
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			bank_t_s2 <= bank_t;
			bank_m_s2 <= bank_m;
			bank_b_s2 <= bank_b;
		end
	end

	always_comb begin
		nw = rd[bank_t_s2][0];
		n  = rd[bank_t_s2][1];
		ne = rd[bank_t_s2][2];
		e  = rd[bank_m_s2][2];
		se = rd[bank_b_s2][2];
		s  = rd[bank_b_s2][1];
		sw = rd[bank_b_s2][0];
		w  = rd[bank_m_s2][0];
		c  = rd[bank_m_s2][1];
		pattern = {nw >= c, n >= c, ne >= c, e >= c, se >= c, s >= c, sw >= c, w >= c};
	end

endmodule

[design/lcf_codetab.sv]
// code table memory with its rebuild sequencer
module lcf_codetab import lcf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [3:0] max_trans,
	input  logic       rot_inv,
	output logic       busy,
	input  logic       re,
	input  logic [7:0] addr,
	output logic [7:0] code,
	output logic [7:0] null_code
);

	build_state_t state_q, state_d;
	logic [7:0]   pat_q, pat_d;
	logic [7:0]   next_q, next_d;
	logic         admit;
	logic [7:0]   mrot;
	logic         ram_we, ram_re;
	logic [7:0]   ram_wdata, ram_raddr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_READ;
			pat_q   <= 8'd0;
			next_q  <= 8'd0;
		end else begin
			state_q <= state_d;
			pat_q   <= pat_d;
			next_q  <= next_d;
		end
	end

	always_comb begin
		admit     = transitions(pat_q) <= max_trans;
		mrot      = min_rotation(pat_q);
		state_d   = state_q;
		pat_d     = pat_q;
		next_d    = next_q;
		ram_we    = 1'b0;
		ram_wdata = next_q;
		ram_re    = 1'b1;
		ram_raddr = mrot;
		unique case (state_q)
			B_IDLE: begin
				ram_re    = re;
				ram_raddr = addr;
			end
			B_READ: begin
				state_d = B_WRITE;
			end
			B_WRITE: begin
				if (admit) begin
					ram_we = 1'b1;
					if (rot_inv && (mrot != pat_q)) begin
						ram_wdata = code;
					end else begin
						next_d = next_q + 8'd1;
					end
				end
				pat_d   = pat_q + 8'd1;
				state_d = (pat_q == 8'hFF) ? B_NULL : B_READ;
			end
			B_NULL: begin
				ram_we  = !admit;
				pat_d   = pat_q + 8'd1;
				state_d = (pat_q == 8'hFF) ? B_IDLE : B_NULL;
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
		if (start) begin
			state_d = B_READ;
			pat_d   = 8'd0;
			next_d  = 8'd0;
		end
	end

	lcf_ram #(
		.WIDTH(8),
		.DEPTH(256)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(pat_q),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(code)
	);

	assign busy      = state_q != B_IDLE;
	assign null_code = next_q;

endmodule

[design/lbp_code_image_filter.sv]
// top level of the 3x3 local binary pattern code filter
// One beat per clock in and out unless a side stalls; a pixel beat that releases a code
// shows it after write and position decode, line store read and table read registers.
// The line store is nine row banks each held in three copies so that all nine neighbours
// read in the same cycle. After reset and every write to a defined register the table is
// rebuilt, a read and a write per pattern and a null pass, while the input is stalled.
module lbp_code_image_filter import lcf_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int MAX_RADIUS = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [CFG_DW-1:0] cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              op,
	input  logic [7:0]        pixel,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        code,
	output logic              last
);

	localparam int NR  = 2 * MAX_RADIUS + 1;
	localparam int BW  = $clog2(NR);
	localparam int CA  = $clog2(MAX_WIDTH);
	localparam int RA  = $clog2(MAX_HEIGHT);
	localparam int WEW = $clog2(MAX_WIDTH + 1);
	localparam int HEW = $clog2(MAX_HEIGHT + 1);
	localparam int REW = $clog2(MAX_RADIUS + 1);
	localparam int XW  = $clog2(MAX_WIDTH + MAX_RADIUS + 1);
	localparam int YW  = $clog2(MAX_HEIGHT + MAX_RADIUS + 1);
	localparam int LW  = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 2);
	localparam int KW  = BW + 2;
	localparam int RST_W   = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
	localparam int RST_H   = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;
	localparam int RST_LAG = RST_W + 1;

	logic [WEW-1:0] w_q, weff;
	logic [HEW-1:0] h_q, heff;
	logic [REW-1:0] r_q, reff;
	logic [3:0]     mt_q;
	logic           rot_q;
	logic [LW-1:0]  lag_q;
	logic           cfg_hit;

	logic [RA-1:0]  irow_q, irow_b, irow_n;
	logic [CA-1:0]  icol_q, icol_b, icol_n;
	logic [BW-1:0]  ibank_q, ibank_b, ibank_n;
	logic           done_q, done_b, done_n;
	logic [HEW-1:0] orow_q, orow_b, orow_n;
	logic [CA-1:0]  ocol_q, ocol_b, ocol_n;
	logic [BW-1:0]  obank_q, obank_b, obank_n;
	logic [LW-1:0]  dcnt_q, dcnt_b, dcnt_n;
	logic           emit, wr;
	logic           border, at_last;
	logic [KW-1:0]  kt, kb;
	logic [BW-1:0]  bank_t, bank_b;
	logic [CA-1:0]  col_l, col_r;

	logic           acc, en1, en2, en3, busy;
	logic           v_s1, border_s1, last_s1;
	logic [BW-1:0]  bt_s1, bm_s1, bb_s1;
	logic [CA-1:0]  cl_s1, cc_s1, cr_s1;
	logic           v_s2, border_s2, last_s2;
	logic           v_s3, border_s3, last_s3;
	logic [7:0]     pattern, tab_code, null_code;

	// register decode and clamping
	always_comb begin
		cfg_hit = 1'b0;
		unique case (cfg_index) inside
			REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_RADIUS,
			REG_MAX_TRANS, REG_ROT_INVARIANT: cfg_hit = cfg_we;
			default: cfg_hit = 1'b0;
		endcase
		if (cfg_data == '0) begin
			weff = WEW'(1);
		end else if (32'(cfg_data) > 32'(MAX_WIDTH)) begin
			weff = WEW'(MAX_WIDTH);
		end else begin
			weff = WEW'(cfg_data);
		end
		if (cfg_data == '0) begin
			heff = HEW'(1);
		end else if (32'(cfg_data) > 32'(MAX_HEIGHT)) begin
			heff = HEW'(MAX_HEIGHT);
		end else begin
			heff = HEW'(cfg_data);
		end
		if (cfg_data[2:0] == 3'd0) begin
			reff = REW'(1);
		end else if (32'(cfg_data[2:0]) > 32'(MAX_RADIUS)) begin
			reff = REW'(MAX_RADIUS);
		end else begin
			reff = REW'(cfg_data[2:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q   <= WEW'(RST_W);
			h_q   <= HEW'(RST_H);
			r_q   <= REW'(1);
			mt_q  <= 4'd8;
			rot_q <= 1'b0;
			lag_q <= LW'(RST_LAG);
		end else begin
			lag_q <= LW'(r_q) * LW'(w_q) + LW'(r_q);
			if (cfg_hit) begin
				unique case (cfg_index)
					REG_IMAGE_WIDTH:   w_q   <= weff;
					REG_IMAGE_HEIGHT:  h_q   <= heff;
					REG_RADIUS:        r_q   <= reff;
					REG_MAX_TRANS:     mt_q  <= cfg_data[3:0];
					REG_ROT_INVARIANT: rot_q <= cfg_data[0];
					default:           rot_q <= rot_q;
				endcase
			end
		end
	end

	// frame position tracking
	always_comb begin
		irow_b  = irow_q;
		icol_b  = icol_q;
		ibank_b = ibank_q;
		done_b  = done_q;
		orow_b  = orow_q;
		ocol_b  = ocol_q;
		obank_b = obank_q;
		dcnt_b  = dcnt_q;
		wr      = 1'b0;
		emit    = 1'b0;
		if (op == OP_PIXEL) begin
			wr = 1'b1;
			if (done_q) begin
				irow_b  = '0;
				icol_b  = '0;
				ibank_b = '0;
				done_b  = 1'b0;
				orow_b  = '0;
				ocol_b  = '0;
				obank_b = '0;
				dcnt_b  = '0;
			end
		end
		irow_n  = irow_b;
		icol_n  = icol_b;
		ibank_n = ibank_b;
		done_n  = done_b;
		dcnt_n  = dcnt_b;
		if (wr) begin
			dcnt_n = dcnt_b + LW'(1);
			if (WEW'(icol_b) + WEW'(1) == w_q) begin
				icol_n  = '0;
				ibank_n = (ibank_b == BW'(NR - 1)) ? '0 : ibank_b + BW'(1);
				if (HEW'(irow_b) + HEW'(1) == h_q) begin
					irow_n  = '0;
					ibank_n = '0;
					done_n  = 1'b1;
				end else begin
					irow_n = irow_b + RA'(1);
				end
			end else begin
				icol_n = icol_b + CA'(1);
			end
			emit = (orow_b < h_q) && (dcnt_n > lag_q);
		end else begin
			emit = done_q && (orow_q < h_q);
		end

		border = !((YW'(orow_b) >= YW'(r_q)) && (YW'(orow_b) + YW'(r_q) < YW'(h_q)) &&
			(XW'(ocol_b) >= XW'(r_q)) && (XW'(ocol_b) + XW'(r_q) < XW'(w_q)));
		at_last = (orow_b == h_q - HEW'(1)) && (WEW'(ocol_b) == w_q - WEW'(1));
		col_l = CA'(XW'(ocol_b) - XW'(r_q));
		col_r = CA'(XW'(ocol_b) + XW'(r_q));
		kt = KW'(obank_b) + KW'(NR) - KW'(r_q);
		kt = (kt >= KW'(NR)) ? kt - KW'(NR) : kt;
		kb = KW'(obank_b) + KW'(r_q);
		kb = (kb >= KW'(NR)) ? kb - KW'(NR) : kb;
		bank_t = BW'(kt);
		bank_b = BW'(kb);

		orow_n  = orow_b;
		ocol_n  = ocol_b;
		obank_n = obank_b;
		if (emit) begin
			dcnt_n = dcnt_n - LW'(1);
			if (WEW'(ocol_b) + WEW'(1) == w_q) begin
				ocol_n  = '0;
				orow_n  = orow_b + HEW'(1);
				obank_n = (obank_b == BW'(NR - 1)) ? '0 : obank_b + BW'(1);
			end else begin
				ocol_n = ocol_b + CA'(1);
			end
		end
	end

	assign en3      = !v_s3 || !out_stall;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_stall = busy || !en1;
	assign acc      = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irow_q  <= '0;
			icol_q  <= '0;
			ibank_q <= '0;
			done_q  <= 1'b0;
			orow_q  <= '0;
			ocol_q  <= '0;
			obank_q <= '0;
			dcnt_q  <= '0;
		end else if (cfg_hit) begin
			irow_q  <= '0;
			icol_q  <= '0;
			ibank_q <= '0;
			done_q  <= 1'b0;
			orow_q  <= '0;
			ocol_q  <= '0;
			obank_q <= '0;
			dcnt_q  <= '0;
		end else if (acc) begin
			irow_q  <= irow_n;
			icol_q  <= icol_n;
			ibank_q <= ibank_n;
			done_q  <= done_n;
			orow_q  <= orow_n;
			ocol_q  <= ocol_n;
			obank_q <= obank_n;
			dcnt_q  <= dcnt_n;
		end
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= acc && emit;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			border_s1 <= border;
			last_s1   <= at_last;
			bt_s1     <= bank_t;
			bm_s1     <= obank_b;
			bb_s1     <= bank_b;
			cl_s1     <= col_l;
			cc_s1     <= ocol_b;
			cr_s1     <= col_r;
		end
		if (en2) begin
			border_s2 <= border_s1;
			last_s2   <= last_s1;
		end
		if (en3) begin
			border_s3 <= border_s2;
			last_s3   <= last_s2;
		end
	end

	lcf_window #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_RADIUS(MAX_RADIUS)
	) u_window (
		.clk    (clk),
		.we     (acc && wr),
		.wbank  (ibank_b),
		.wcol   (icol_b),
		.wdata  (pixel),
		.re     (en2),
		.bank_t (bt_s1),
		.bank_m (bm_s1),
		.bank_b (bb_s1),
		.col_l  (cl_s1),
		.col_c  (cc_s1),
		.col_r  (cr_s1),
		.pattern(pattern)
	);

	lcf_codetab u_codetab (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cfg_hit),
		.max_trans(mt_q),
		.rot_inv  (rot_q),
		.busy     (busy),
		.re       (en3),
		.addr     (pattern),
		.code     (tab_code),
		.null_code(null_code)
	);

	assign out_valid = v_s3;
	assign code      = border_s3 ? null_code : tab_code;
	assign last      = last_s3;

	a_backlog_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dcnt_q <= lag_q + LW'(1))
		else $error("pixel backlog beyond the output lag");

	a_last_is_null: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> code == null_code)
		else $error("final position of a frame carries a non-null code");

	a_build_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> !v_s1 && !v_s2 && !v_s3)
		else $error("table rebuild finished with beats in flight");

endmodule

[tb/tb_top.sv]
// self-checking testbench of the lbp code image filter with its own code predictor
`timescale 1ns / 1ps
module tb_top import lcf_pkg::*; ();

	typedef struct packed {
		logic       op;
		logic [7:0] pix;
	} pix_beat_t;

	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} code_beat_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [2:0]        cfg_index;
	logic [CFG_DW-1:0] cfg_data;
	logic              in_valid;
	logic              in_stall;
	logic              op;
	logic [7:0]        pixel;
	logic              out_valid;
	logic              out_stall;
	logic [7:0]        code;
	logic              last;

	lbp_code_image_filter u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall), .op(op),
		.pixel(pixel), .out_valid(out_valid), .out_stall(out_stall), .code(code),
		.last(last)
	);

	pix_beat_t  pixel_q[$];
	code_beat_t code_q[$];

	// predictor state
	logic [7:0] line_mem [0:9*1024-1];
	logic [7:0] code_map [0:255];
	logic [7:0] null_val;
	int         in_row, in_col, out_row, out_col;
	bit         frame_in_done;
	int         reg_w, reg_h, reg_r, reg_mt, reg_ri;

	int  idle_pct, stall_pct, hold_cycles;
	int  errors, codes_seen, beats_in, frames_sent, cfg_sets, quiet_cycles;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int eff_w();
		return reg_w == 0 ? 1 : (reg_w > 1024 ? 1024 : reg_w);
	endfunction
	function automatic int eff_h();
		return reg_h == 0 ? 1 : (reg_h > 1024 ? 1024 : reg_h);
	endfunction
	function automatic int eff_r();
		return reg_r == 0 ? 1 : (reg_r > 4 ? 4 : reg_r);
	endfunction

	function automatic logic [7:0] lowest_rotation(input logic [7:0] p);
		logic [7:0] v;
		logic [7:0] low;
		v = p;
		low = p;
		for (int k = 0; k < 8; k++) begin
			v = {v[0], v[7:1]};
			if (v < low) low = v;
		end
		return low;
	endfunction

	task automatic rebuild_codes();
		bit   ok [256];
		int   nxt;
		logic [7:0] p;
		nxt = 0;
		for (int i = 0; i < 256; i++) begin
			p = i[7:0];
			ok[i] = $countones(p ^ {p[0], p[7:1]}) <= reg_mt;
			if (ok[i]) begin
				if (reg_ri != 0 && lowest_rotation(p) != p) begin
					code_map[i] = code_map[lowest_rotation(p)];
				end else begin
					code_map[i] = nxt[7:0];
					nxt++;
				end
			end
		end
		null_val = nxt[7:0];
		for (int i = 0; i < 256; i++)
			if (!ok[i]) code_map[i] = null_val;
	endtask

	task automatic clear_counts();
		in_row = 0;
		in_col = 0;
		out_row = 0;
		out_col = 0;
		frame_in_done = 0;
	endtask

	function automatic logic [7:0] px_at(input int row, input int col);
		return line_mem[(row % 9) * 1024 + (col % 1024)];
	endfunction

	task automatic emit_code();
		int w, h, r, y, x;
		logic [7:0] c;
		logic [7:0] pat;
		code_beat_t b;
		w = eff_w();
		h = eff_h();
		r = eff_r();
		y = out_row;
		x = out_col;
		b.code = null_val;
		if (y >= r && y + r < h && x >= r && x + r < w) begin
			c = px_at(y, x);
			pat[7] = px_at(y - r, x - r) >= c;
			pat[6] = px_at(y - r, x) >= c;
			pat[5] = px_at(y - r, x + r) >= c;
			pat[4] = px_at(y, x + r) >= c;
			pat[3] = px_at(y + r, x + r) >= c;
			pat[2] = px_at(y + r, x) >= c;
			pat[1] = px_at(y + r, x - r) >= c;
			pat[0] = px_at(y, x - r) >= c;
			b.code = code_map[pat];
		end
		b.last = (y == h - 1 && x == w - 1);
		code_q.insert(code_q.size(), b);
		out_col++;
		if (out_col >= w) begin
			out_col = 0;
			out_row++;
		end
	endtask

	task automatic predict_beat(input logic o, input logic [7:0] px);
		int w, h, r, cnt_in, lin_out;
		w = eff_w();
		h = eff_h();
		r = eff_r();
		if (o == OP_FLUSH) begin
			if (frame_in_done && out_row < h) emit_code();
		end else begin
			if (frame_in_done) clear_counts();
			line_mem[(in_row % 9) * 1024 + (in_col % 1024)] = px;
			in_col++;
			if (in_col >= w) begin
				in_col = 0;
				in_row++;
				if (in_row >= h) begin
					in_row = 0;
					frame_in_done = 1;
				end
			end
			cnt_in = frame_in_done ? w * h : in_row * w + in_col;
			lin_out = out_row * w + out_col;
			if (lin_out < w * h && cnt_in >= lin_out + r * w + r + 1) emit_code();
		end
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			op <= OP_PIXEL;
			pixel <= 8'd0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_beat(op, pixel);
				beats_in++;
			end
			if (!in_valid || !in_stall) begin
				if (pixel_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
					op <= pixel_q[0].op;
					pixel <= pixel_q[0].pix;
					void'(pixel_q.pop_front());
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		code_beat_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				codes_seen++;
				if (code_q.size() == 0) begin
					$display("%0t: unexpected beat code=%0d last=%0b", $time, code, last);
					errors++;
				end else begin
					want = code_q.pop_front();
					if (code !== want.code) begin
						$display("%0t: code mismatch expected %0d actual %0d",
							$time, want.code, code);
						errors++;
					end
					if (last !== want.last) begin
						$display("%0t: last mismatch expected %0b actual %0b",
							$time, want.last, last);
						errors++;
					end
				end
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= $urandom_range(99) < stall_pct;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we ||
			(pixel_q.size() == 0 && code_q.size() == 0 && !in_valid)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= 20000) begin
				$display("%0t: no progress, %0d codes outstanding", $time, code_q.size());
				$display("lbp_code_image_filter test failed");
				$finish;
			end
		end
	end

	task automatic wait_idle();
		wait (pixel_q.size() == 0 && !in_valid && code_q.size() == 0);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input int val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_DW-1:0];
		case (idx)
			REG_IMAGE_WIDTH:   reg_w = val & 'h7ff;
			REG_IMAGE_HEIGHT:  reg_h = val & 'h7ff;
			REG_RADIUS:        reg_r = val & 'h7;
			REG_MAX_TRANS:     reg_mt = val & 'hf;
			REG_ROT_INVARIANT: reg_ri = val & 'h1;
			default:           return;
		endcase
		rebuild_codes();
		clear_counts();
	endtask

	task automatic set_regs(input int w, input int h, input int r, input int mt, input int ri);
		wait_idle();
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		write_reg(REG_RADIUS, r);
		write_reg(REG_MAX_TRANS, mt);
		write_reg(REG_ROT_INVARIANT, ri);
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_sets++;
	endtask

	task automatic set_idling(input int mode);
		case (mode % 4)
			0: begin idle_pct = 0; stall_pct = 0; end
			1: begin idle_pct = 69; stall_pct = 0; end
			2: begin idle_pct = 0; stall_pct = 69; end
			default: begin idle_pct = 7; stall_pct = 7; end
		endcase
	endtask

	task automatic push_beat(input logic o, input logic [7:0] px);
		pix_beat_t b;
		b.op = o;
		b.pix = px;
		pixel_q.insert(pixel_q.size(), b);
	endtask

	// style 0 random, 1 flat, 2 black and white; pause_mid waits for the drain halfway
	task automatic queue_frame(input int style, input int drain, input bit pause_mid);
		int n;
		logic [7:0] flat;
		n = eff_w() * eff_h();
		flat = 8'($urandom_range(255));
		for (int i = 0; i < n; i++) begin
			case (style)
				0: push_beat(OP_PIXEL, 8'($urandom_range(255)));
				1: push_beat(OP_PIXEL, flat);
				default: push_beat(OP_PIXEL, $urandom_range(1) ? 8'hff : 8'h00);
			endcase
			if (pause_mid && i == n / 2) wait_idle();
		end
		for (int i = 0; i < drain; i++) push_beat(OP_FLUSH, 8'($urandom_range(255)));
		frames_sent++;
	endtask

	initial begin
		int w, h, r, full, rand_beats, mode;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_IMAGE_WIDTH;
		cfg_data = '0;
		idle_pct = 0;
		stall_pct = 0;
		hold_cycles = 0;
		errors = 0;
		codes_seen = 0;
		beats_in = 0;
		frames_sent = 0;
		cfg_sets = 0;
		quiet_cycles = 0;
		reg_w = 1024;
		reg_h = 1024;
		reg_r = 1;
		reg_mt = 8;
		reg_ri = 0;
		rebuild_codes();
		clear_counts();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset registers: a partial frame, flush while arriving is ignored
		for (int i = 0; i < 6; i++) push_beat(OP_PIXEL, i[0] ? 8'hff : 8'h00);
		push_beat(OP_FLUSH, 8'h00);

		// directed frame with extreme pixels, flushes past the end, ignored index
		set_regs(5, 4, 1, 8, 0);
		wait_idle();
		write_reg(3'd7, 'h7ff);
		@(posedge clk);
		cfg_we <= 1'b0;
		push_beat(OP_PIXEL, 8'h00);
		push_beat(OP_PIXEL, 8'hff);
		push_beat(OP_FLUSH, 8'hff);
		for (int i = 0; i < 18; i++) push_beat(OP_PIXEL, $urandom_range(1) ? 8'hff : 8'h00);
		for (int i = 0; i < 9; i++) push_beat(OP_FLUSH, 8'h00);

		// register extremes, sender pauses for the drain in the middle of a frame
		set_regs(9, 9, 7, 15, 1);
		queue_frame(0, 50, 1);
		// clamped width, partial frame dropped by the next write
		set_regs(2047, 1, 0, 0, 1);
		set_idling(3);
		for (int i = 0; i < 60; i++) push_beat(OP_PIXEL, 8'($urandom_range(255)));
		push_beat(OP_FLUSH, 8'h00);
		// clamped height, one column, partial frame
		set_regs(1, 2047, 4, 0, 0);
		for (int i = 0; i < 40; i++) push_beat(OP_PIXEL, $urandom_range(1) ? 8'hff : 8'h00);
		for (int i = 0; i < 6; i++) push_beat(OP_FLUSH, 8'h00);
		set_regs(0, 0, 1, 2, 0);
		queue_frame(0, 2, 0);

		// random part
		rand_beats = 0;
		mode = 0;
		while (rand_beats < 350) begin
			w = $urandom_range(1, 12);
			h = $urandom_range(1, 10);
			r = $urandom_range(3) == 0 ? $urandom_range(7) : $urandom_range(1, 2);
			set_regs(w, h, r, $urandom_range(15), $urandom_range(1));
			set_idling(mode);
			if (mode == 0) hold_cycles = 400;
			for (int f = 0; f < $urandom_range(1, 3); f++) begin
				full = eff_r() * eff_w() + eff_r() + 2;
				if ($urandom_range(3) == 0) push_beat(OP_FLUSH, 8'($urandom_range(255)));
				queue_frame($urandom_range(5) == 0 ? $urandom_range(1, 2) : 0,
					$urandom_range(4) == 0 ? $urandom_range(full) : full, mode == 1);
				rand_beats += eff_w() * eff_h() + full;
			end
			mode++;
		end

		wait_idle();
		$display("covered %0d input beats in %0d frames over %0d register settings",
			beats_in, frames_sent, cfg_sets);
		$display("checked %0d codes, %0d mismatches", codes_seen, errors);
		if (errors == 0) begin
			$display("lbp_code_image_filter test passed");
		end else begin
			$display("lbp_code_image_filter test failed");
		end
		$finish;
	end

endmodule
